>>> rtl/core/nbt_pkg.sv
// ----------------------------------------------------------------------------
// nbt_pkg
// Shared types and codes for the tag stream tokenizer.
// ----------------------------------------------------------------------------
package nbt_pkg;

  localparam logic [3:0] K_END      = 4'd0;
  localparam logic [3:0] K_BYTEARR  = 4'd7;
  localparam logic [3:0] K_STRING   = 4'd8;
  localparam logic [3:0] K_LIST     = 4'd9;
  localparam logic [3:0] K_COMPOUND = 4'd10;
  localparam logic [3:0] K_INTARR   = 4'd11;
  localparam logic [3:0] K_LONGARR  = 4'd12;

  localparam logic [3:0] R_TAG      = 4'd0;
  localparam logic [3:0] R_NAMELEN  = 4'd1;
  localparam logic [3:0] R_NAME     = 4'd2;
  localparam logic [3:0] R_SCALAR   = 4'd3;
  localparam logic [3:0] R_LISTTYPE = 4'd4;
  localparam logic [3:0] R_COUNT    = 4'd5;
  localparam logic [3:0] R_STRLEN   = 4'd6;
  localparam logic [3:0] R_STRCHR   = 4'd7;
  localparam logic [3:0] R_ARRELEM  = 4'd8;
  localparam logic [3:0] R_ENDTAG   = 4'd9;
  localparam logic [3:0] R_IGNORED  = 4'd10;

  localparam logic [2:0] E_NONE   = 3'd0;
  localparam logic [2:0] E_TAG    = 3'd1;
  localparam logic [2:0] E_DEEP   = 3'd2;
  localparam logic [2:0] E_NEG    = 3'd3;
  localparam logic [2:0] E_TRUNC  = 3'd4;

  typedef enum logic [3:0] {
    M_TAG, M_NAMELEN, M_NAME, M_SCALAR, M_LISTTYPE,
    M_COUNT, M_STRLEN, M_STRCHR, M_ARRELEM
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_POP  = 3'b010,
    S_OUT  = 3'b100
  } ctl_state_t;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic pop_step;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pop_pending;
  } dp_sts_t;

  typedef struct packed {
    logic [3:0] byte_role;
    logic [3:0] tag_kind;
    logic [4:0] nest_depth;
    logic [7:0] byte_out;
    logic       field_done;
    logic [2:0] error_code;
  } result_t;

  function automatic logic [3:0] scalar_size(input logic [3:0] t);
    case (t)
      4'd1: scalar_size = 4'd1;
      4'd2: scalar_size = 4'd2;
      4'd3: scalar_size = 4'd4;
      4'd4: scalar_size = 4'd8;
      4'd5: scalar_size = 4'd4;
      4'd6: scalar_size = 4'd8;
      default: scalar_size = 4'd0;
    endcase
  endfunction

endpackage

>>> rtl/core/nbt_if.sv
// ----------------------------------------------------------------------------
// nbt_in_if / nbt_out_if
// Valid/ready channels for stream bytes and tokens.
// ----------------------------------------------------------------------------
interface nbt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  logic       buffer_last;
  modport source (output valid, output stream_byte, output buffer_last, input ready);
  modport sink (input valid, input stream_byte, input buffer_last, output ready);
endinterface

interface nbt_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] byte_role;
  logic [3:0] tag_kind;
  logic [4:0] nest_depth;
  logic [7:0] byte_out;
  logic       field_done;
  logic [2:0] error_code;
  modport source (output valid, output byte_role, output tag_kind, output nest_depth,
                  output byte_out, output field_done, output error_code, input ready);
  modport sink (input valid, input byte_role, input tag_kind, input nest_depth,
                input byte_out, input field_done, input error_code, output ready);
endinterface

>>> rtl/core/nbt_datapath.sv
// ----------------------------------------------------------------------------
// nbt_datapath
// Parse registers, frame stack and per-byte classification. A value end
// that pops finished list frames is resolved one frame per pop step.
// ----------------------------------------------------------------------------
module nbt_datapath
  import nbt_pkg::*;
#(
  parameter int MAX_DEPTH = 16,
  parameter int SW = $clog2(MAX_DEPTH + 1),
  parameter int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [4:0] depth_limit,
  input  logic [7:0] stream_byte,
  input  logic       buffer_last,
  input  dp_cmd_t    cmd,
  output dp_sts_t    sts,
  output result_t    res
);

  localparam logic [SW-1:0] MAXD = SW'(MAX_DEPTH);

  mode_t       mode_r, mode_nxt;
  logic [39:0] left_r, left_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [3:0]  tag_r, tag_nxt;
  logic [SW-1:0] top_r, top_nxt;
  logic [2:0]  err_r, err_nxt;
  logic        pend_r, pend_nxt;
  logic        push_r, push_nxt;
  logic        last_r;
  result_t     res_r, res_nxt;

  logic [36:0] stack_mem [MAX_DEPTH];
  logic        wr_en;
  logic [AW-1:0] wr_addr;
  logic [36:0] wr_data;
  logic [36:0] top_frame;
  logic [SW-1:0] lim;
  logic [SW-1:0] lim_ext;

  assign lim_ext = (SW > 5) ? SW'(depth_limit) : SW'(depth_limit);
  assign lim = ((SW > 5) ? ({27'd0, depth_limit} < 32'(MAX_DEPTH))
                         : (32'(depth_limit) < 32'(MAX_DEPTH))) ? lim_ext : MAXD;

  // top frame is registered from the next stack top, so it follows top_r
  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    top_frame <= stack_mem[AW'(top_nxt - SW'(1))];
  end

  assign sts.pop_pending = pend_r | push_r;
  assign res = res_r;

  always_comb begin
    logic [3:0]  role;
    logic [3:0]  kind;
    logic        done;
    logic [2:0]  e;
    logic        endv;
    logic        begv;
    logic [3:0]  bt;
    logic [31:0] a;
    logic [7:0]  c;
    logic [3:0]  esz;
    logic [SW-1:0] t;
    mode_nxt = mode_r;
    left_nxt = left_r;
    acc_nxt  = acc_r;
    tag_nxt  = tag_r;
    top_nxt  = top_r;
    err_nxt  = err_r;
    pend_nxt = pend_r;
    push_nxt = push_r;
    res_nxt  = res_r;
    wr_en    = 1'b0;
    wr_addr  = AW'(top_r);
    wr_data  = '0;
    role = R_IGNORED;
    kind = tag_r;
    done = 1'b0;
    e    = E_NONE;
    endv = 1'b0;
    begv = 1'b0;
    bt   = tag_r;
    a    = 32'd0;
    c    = 8'd0;
    t    = top_r;
    esz  = (tag_r == K_LONGARR) ? 4'd8 : ((tag_r == K_INTARR) ? 4'd4 : 4'd1);

    if (cmd.start) begin
      if (err_r != E_NONE) begin
        kind = 4'd0;
      end else begin
        case (mode_r)
          M_TAG: begin
            done = 1'b1;
            if (stream_byte == 8'(K_END)) begin
              role = R_ENDTAG;
              kind = 4'd0;
              if (top_r != '0) begin
                t = top_r - SW'(1);
                top_nxt = t;
                endv = 1'b1;
              end
            end else if (stream_byte > 8'(K_LONGARR)) begin
              role = R_TAG;
              kind = 4'd0;
              e = E_TAG;
            end else begin
              role = R_TAG;
              kind = stream_byte[3:0];
              tag_nxt = stream_byte[3:0];
              mode_nxt = M_NAMELEN;
              left_nxt = 40'd2;
              acc_nxt = 32'd0;
            end
          end
          M_NAMELEN, M_STRLEN: begin
            role = (mode_r == M_NAMELEN) ? R_NAMELEN : R_STRLEN;
            a = {acc_r[23:0], stream_byte};
            acc_nxt = a;
            left_nxt = (left_r != 0) ? left_r - 40'd1 : 40'd0;
            if (left_nxt == 0) begin
              done = 1'b1;
              if (a == 0) begin
                if (mode_r == M_NAMELEN) begin
                  begv = 1'b1;
                end else begin
                  endv = 1'b1;
                end
              end else begin
                mode_nxt = (mode_r == M_NAMELEN) ? M_NAME : M_STRCHR;
                left_nxt = {8'd0, a};
              end
            end
          end
          M_NAME, M_SCALAR, M_STRCHR: begin
            role = (mode_r == M_NAME) ? R_NAME : ((mode_r == M_SCALAR) ? R_SCALAR : R_STRCHR);
            left_nxt = (left_r != 0) ? left_r - 40'd1 : 40'd0;
            if (left_nxt == 0) begin
              done = 1'b1;
              if (mode_r == M_NAME) begin
                begv = 1'b1;
              end else begin
                endv = 1'b1;
              end
            end
          end
          M_LISTTYPE: begin
            role = R_LISTTYPE;
            kind = K_LIST;
            done = 1'b1;
            if (stream_byte > 8'(K_LONGARR)) begin
              e = E_TAG;
            end else begin
              mode_nxt = M_COUNT;
              left_nxt = {28'd0, stream_byte[3:0], 8'd4};
              acc_nxt = 32'd0;
            end
          end
          M_COUNT: begin
            role = R_COUNT;
            a = {acc_r[23:0], stream_byte};
            acc_nxt = a;
            c = (left_r[7:0] != 0) ? left_r[7:0] - 8'd1 : 8'd0;
            left_nxt = {left_r[39:8], c};
            if (c == 0) begin
              done = 1'b1;
              if (a[31]) begin
                e = E_NEG;
              end else if (tag_r == K_LIST) begin
                if (a == 0 || left_r[11:8] == K_END) begin
                  endv = 1'b1;
                end else if (top_r >= lim) begin
                  e = E_DEEP;
                end else begin
                  wr_en = 1'b1;
                  wr_addr = AW'(top_r);
                  wr_data = {1'b1, left_r[11:8], a};
                  top_nxt = top_r + SW'(1);
                  bt = left_r[11:8];
                  begv = 1'b1;
                end
              end else if (a == 0) begin
                endv = 1'b1;
              end else begin
                mode_nxt = M_ARRELEM;
                left_nxt = ({8'd0, a} << ((esz == 4'd8) ? 3 : ((esz == 4'd4) ? 2 : 0)));
              end
            end
          end
          M_ARRELEM: begin
            role = R_ARRELEM;
            left_nxt = (left_r != 0) ? left_r - 40'd1 : 40'd0;
            done = (left_nxt[2:0] & 3'(esz - 4'd1)) == 3'd0;
            if (left_nxt == 0) begin
              endv = 1'b1;
            end
          end
          default: begin
            mode_nxt = M_TAG;
            kind = 4'd0;
          end
        endcase

        if (begv) begin
          tag_nxt = bt;
          if (bt >= 4'd1 && bt <= 4'd6) begin
            mode_nxt = M_SCALAR;
            left_nxt = {36'd0, scalar_size(bt)};
          end else if (bt == K_BYTEARR || bt == K_INTARR || bt == K_LONGARR) begin
            mode_nxt = M_COUNT;
            left_nxt = 40'd4;
            acc_nxt = 32'd0;
          end else if (bt == K_STRING) begin
            mode_nxt = M_STRLEN;
            left_nxt = 40'd2;
            acc_nxt = 32'd0;
          end else if (bt == K_LIST) begin
            mode_nxt = M_LISTTYPE;
          end else if (bt == K_COMPOUND) begin
            if (wr_en) begin
              // list frame written this cycle, compound frame next step
              push_nxt = 1'b1;
              mode_nxt = M_TAG;
            end else if (top_nxt >= lim) begin
              e = E_DEEP;
            end else begin
              wr_en = 1'b1;
              wr_addr = AW'(top_nxt);
              wr_data = '0;
              top_nxt = top_nxt + SW'(1);
              mode_nxt = M_TAG;
            end
          end else begin
            mode_nxt = M_TAG;
          end
        end
        if (endv) begin
          mode_nxt = M_TAG;
          pend_nxt = 1'b1;
        end
      end
      res_nxt.byte_role  = role;
      res_nxt.tag_kind   = kind;
      res_nxt.nest_depth = 5'(top_r);
      res_nxt.byte_out   = stream_byte;
      res_nxt.field_done = done & (e == E_NONE);
      if (e != E_NONE) begin
        err_nxt = e;
        pend_nxt = 1'b0;
        push_nxt = 1'b0;
      end
    end else if (cmd.pop_step) begin
      if (push_r) begin
        // compound opened as a list element
        push_nxt = 1'b0;
        if (top_r >= lim) begin
          e = E_DEEP;
        end else begin
          wr_en = 1'b1;
          wr_addr = AW'(top_r);
          wr_data = '0;
          top_nxt = top_r + SW'(1);
          mode_nxt = M_TAG;
        end
      end else if (top_r == '0 || top_r > MAXD || !top_frame[36]) begin
        // no list frame on top: the value-end walk ends here
        pend_nxt = 1'b0;
      end else if (top_frame[31:0] > 32'd1) begin
        pend_nxt = 1'b0;
        wr_en = 1'b1;
        wr_addr = AW'(top_r - SW'(1));
        wr_data = {top_frame[36:32], top_frame[31:0] - 32'd1};
        bt = top_frame[35:32];
        tag_nxt = bt;
        if (bt >= 4'd1 && bt <= 4'd6) begin
          mode_nxt = M_SCALAR;
          left_nxt = {36'd0, scalar_size(bt)};
        end else if (bt == K_BYTEARR || bt == K_INTARR || bt == K_LONGARR) begin
          mode_nxt = M_COUNT;
          left_nxt = 40'd4;
          acc_nxt = 32'd0;
        end else if (bt == K_STRING) begin
          mode_nxt = M_STRLEN;
          left_nxt = 40'd2;
          acc_nxt = 32'd0;
        end else if (bt == K_LIST) begin
          mode_nxt = M_LISTTYPE;
        end else if (bt == K_COMPOUND) begin
          push_nxt = 1'b1;
          mode_nxt = M_TAG;
        end else begin
          mode_nxt = M_TAG;
        end
      end else begin
        top_nxt = top_r - SW'(1);
      end
      if (e != E_NONE) begin
        err_nxt = e;
        pend_nxt = 1'b0;
        res_nxt.field_done = 1'b0;
      end
    end else begin
      if (!pend_r && last_r && err_r == E_NONE && !(mode_r == M_TAG && top_r == '0)) begin
        err_nxt = E_TRUNC;
      end
      res_nxt.error_code = err_nxt;
    end
    if (cmd.start) begin
      res_nxt.error_code = err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_TAG;
      left_r <= '0;
      acc_r  <= '0;
      tag_r  <= '0;
      top_r  <= '0;
      err_r  <= E_NONE;
      pend_r <= 1'b0;
      push_r <= 1'b0;
      last_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      left_r <= left_nxt;
      acc_r  <= acc_nxt;
      tag_r  <= tag_nxt;
      top_r  <= top_nxt;
      err_r  <= err_nxt;
      pend_r <= pend_nxt;
      push_r <= push_nxt;
      if (cmd.start) begin
        last_r <= buffer_last & (err_r == E_NONE);
      end else if (!cmd.pop_step) begin
        last_r <= 1'b0;
      end
    end
    res_r <= res_nxt;
  end

endmodule

>>> rtl/core/nbt_ctrl.sv
// ----------------------------------------------------------------------------
// nbt_ctrl
// Sequencer: take a byte, walk pending list pops and compound pushes, then present the token.
// ----------------------------------------------------------------------------
module nbt_ctrl
  import nbt_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  ctl_state_t state_r, state_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign cmd.start = (state_r == S_IDLE) && in_valid;
  assign cmd.pop_step = (state_r == S_POP) && sts.pop_pending;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) begin
        state_nxt = S_POP;
      end
      S_POP: if (!sts.pop_pending) begin
        state_nxt = S_OUT;
      end
      S_OUT: if (out_ready) begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/core/nbt_stream_tokenizer.sv
// ----------------------------------------------------------------------------
// nbt_stream_tokenizer
// Byte-serial tokenizer for tag streams with a list/compound frame stack.
// Sequence: take a byte, run pending pop steps, then present the token.
// Value ends walk finished list frames; list-element compounds push a frame.
// A new byte is taken only once the last token is accepted, set by the sequencer.
// Reset: synchronous active-low rst_n; stack contents left undefined.
// ----------------------------------------------------------------------------
module nbt_stream_tokenizer
  import nbt_pkg::*;
#(
  parameter int MAX_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata,
  nbt_in_if.sink     in_ch,
  nbt_out_if.source  out_ch
);

  logic [4:0] limit_r;
  dp_cmd_t    cmd;
  dp_sts_t    sts;
  result_t    res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= 5'd16;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  nbt_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts, .cmd
  );

  nbt_datapath #(.MAX_DEPTH(MAX_DEPTH)) u_dp (
    .clk, .rst_n, .depth_limit(limit_r),
    .stream_byte(in_ch.stream_byte), .buffer_last(in_ch.buffer_last),
    .cmd, .sts, .res
  );

  assign out_ch.byte_role  = res.byte_role;
  assign out_ch.tag_kind   = res.tag_kind;
  assign out_ch.nest_depth = res.nest_depth;
  assign out_ch.byte_out   = res.byte_out;
  assign out_ch.field_done = res.field_done;
  assign out_ch.error_code = res.error_code;

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid)) else $error("ready and valid together");
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.error_code != E_NONE) |=> out_ch.error_code != E_NONE)
    else $error("error cleared");
  a_done_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.byte_role == R_IGNORED) |-> !out_ch.field_done)
    else $error("done on ignored item");

endmodule
